FILE: rtl/alfr_pkg.sv
// Package for the additive lagged-Fibonacci generator: types, codes and constants.
package alfr_pkg;

    // Operation codes on the input channel
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Park-Miller minimal standard constants (Schrage form)
    localparam logic [14:0] PM_MULT = 15'd16807;
    localparam logic [16:0] PM_Q    = 17'd127773;
    localparam logic [11:0] PM_R    = 12'd2836;
    localparam logic [30:0] PM_MOD  = 31'h7fffffff;

    // Reciprocal of PM_Q scaled by 2^PM_Q_SHIFT, rounded up: exact quotient for
    // magnitudes up to 2^31, since magnitude times rounding error stays below 2^48
    localparam int          PM_Q_SHIFT = 48;
    localparam logic [31:0] PM_Q_RECIP = 32'((64'd1 << PM_Q_SHIFT) / 64'(PM_Q) + 64'd1);

    // Draws thrown away after a reseed, per ring entry
    localparam int DISCARD_FACTOR = 10;

    // Quotient of a 32-bit magnitude by PM_Q fits in 15 bits, remainder in 17
    localparam int QUO_W = 15;
    localparam int REM_W = 17;

    // Main sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW_RD,
        S_DRAW_WR,
        S_SEED_FIRST,
        S_SEED_RUN,
        S_SEED_WAIT,
        S_DISC_RD,
        S_DISC_WR
    } t_state;

    // Schrage step sequencer
    typedef enum logic [2:0] {
        SCH_IDLE,
        SCH_DIV,
        SCH_REM,
        SCH_MUL_LO,
        SCH_MUL_HI,
        SCH_SUB,
        SCH_FIX
    } t_sch_state;

endpackage

FILE: rtl/alfr_if.sv
// Valid/ready channel interfaces for the generator's request and result streams.
interface alfr_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] seed_value;

    modport source (output valid, output operation, output seed_value, input ready);
    modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

interface alfr_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

FILE: rtl/alfr_schrage.sv
// One Park-Miller step by Schrage's method on a single shared multiplier.
module alfr_schrage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_word,
    output logic        o_done,
    output logic [31:0] o_word
);

    alfr_pkg::t_sch_state r_state, n_state;

    logic                          r_neg, n_neg;
    logic [31:0]                   r_rem, n_rem;
    logic [alfr_pkg::QUO_W-1:0]    r_quo, n_quo;
    logic [31:0]                   r_p_lo, n_p_lo;
    logic [31:0]                   r_p_hi, n_p_hi;
    logic [32:0]                   r_diff, n_diff;

    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_prod;
    logic [32:0] w_fixed;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= alfr_pkg::SCH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_p_lo <= n_p_lo;
        r_p_hi <= n_p_hi;
        r_diff <= n_diff;
    end

    // Operand select for the shared multiplier
    always_comb begin
        w_mul_a = r_rem;
        w_mul_b = alfr_pkg::PM_Q_RECIP;
        case (r_state)
            alfr_pkg::SCH_DIV: begin
                // quotient by reciprocal multiplication
                w_mul_a = r_rem;
                w_mul_b = alfr_pkg::PM_Q_RECIP;
            end
            alfr_pkg::SCH_REM: begin
                w_mul_a = 32'(r_quo);
                w_mul_b = 32'(alfr_pkg::PM_Q);
            end
            alfr_pkg::SCH_MUL_LO: begin
                w_mul_a = 32'(r_rem[alfr_pkg::REM_W-1:0]);
                w_mul_b = 32'(alfr_pkg::PM_MULT);
            end
            alfr_pkg::SCH_MUL_HI: begin
                w_mul_a = 32'(r_quo);
                w_mul_b = 32'(alfr_pkg::PM_R);
            end
            default: begin
                w_mul_a = r_rem;
                w_mul_b = alfr_pkg::PM_Q_RECIP;
            end
        endcase
    end

    assign w_prod = 64'(w_mul_a) * 64'(w_mul_b);

    // Negative result wraps by adding the modulus
    assign w_fixed = r_diff + 33'(alfr_pkg::PM_MOD);

    // Next state and datapath
    always_comb begin
        n_state = r_state;
        n_neg   = r_neg;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_p_lo  = r_p_lo;
        n_p_hi  = r_p_hi;
        n_diff  = r_diff;
        o_done  = 1'b0;
        o_word  = r_diff[31:0];
        case (r_state)
            alfr_pkg::SCH_IDLE: begin
                if (i_start) begin
                    // truncating division works on the magnitude, sign applied later
                    n_neg   = i_word[31];
                    n_rem   = i_word[31] ? (~i_word + 32'd1) : i_word;
                    n_state = alfr_pkg::SCH_DIV;
                end
            end
            alfr_pkg::SCH_DIV: begin
                n_quo   = w_prod[alfr_pkg::PM_Q_SHIFT +: alfr_pkg::QUO_W];
                n_state = alfr_pkg::SCH_REM;
            end
            alfr_pkg::SCH_REM: begin
                // remainder is the magnitude less quotient times divisor
                n_rem   = r_rem - w_prod[31:0];
                n_state = alfr_pkg::SCH_MUL_LO;
            end
            alfr_pkg::SCH_MUL_LO: begin
                n_p_lo  = w_prod[31:0];
                n_state = alfr_pkg::SCH_MUL_HI;
            end
            alfr_pkg::SCH_MUL_HI: begin
                n_p_hi  = w_prod[31:0];
                n_state = alfr_pkg::SCH_SUB;
            end
            alfr_pkg::SCH_SUB: begin
                // negative input negates both quotient and remainder
                n_diff  = r_neg ? ({1'b0, r_p_hi} - {1'b0, r_p_lo})
                                : ({1'b0, r_p_lo} - {1'b0, r_p_hi});
                n_state = alfr_pkg::SCH_FIX;
            end
            alfr_pkg::SCH_FIX: begin
                o_done  = 1'b1;
                o_word  = r_diff[32] ? w_fixed[31:0] : r_diff[31:0];
                n_state = alfr_pkg::SCH_IDLE;
            end
            default: begin
                n_state = alfr_pkg::SCH_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/additive_lagged_fibonacci_rng_core.sv
// Additive lagged-Fibonacci generator top level: ring memory, draw and reseed sequencer.
// Draw: ring read (S_DRAW_RD), then add, write back and load the result register
//   (S_DRAW_WR, held until the result register is free); input ready only in S_IDLE.
// Reseed: seed word to entry 0, one Schrage step per further entry, then
//   DISCARD_FACTOR*TABLE_DEGREE discarded draws (310 at degree 31).
// Reset: runs the seed-one reseed; input ready stays low until it finishes.
module additive_lagged_fibonacci_rng_core #(
    parameter int TABLE_DEGREE   = 31,
    parameter int LAG_SEPARATION = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    alfr_in_if.sink    i_in,
    alfr_out_if.source o_out
);

    localparam int IW     = $clog2(TABLE_DEGREE);
    localparam int DISC_N = alfr_pkg::DISCARD_FACTOR * TABLE_DEGREE;
    localparam int CW     = $clog2(DISC_N);

    localparam logic [IW-1:0] SEP      = IW'(LAG_SEPARATION % TABLE_DEGREE);
    localparam logic [IW-1:0] IDX_LAST = IW'(TABLE_DEGREE - 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(DISC_N - 1);

    alfr_pkg::t_state r_state, n_state;

    logic [IW-1:0] r_front, n_front;
    logic [IW-1:0] r_rear,  n_rear;
    logic [IW-1:0] r_idx,   n_idx;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [31:0]   r_word,  n_word;
    logic          r_out_valid, n_out_valid;
    logic [30:0]   r_out_data,  n_out_data;

    // Ring memory and its registered read data
    logic [31:0]   r_mem [TABLE_DEGREE];
    logic [31:0]   r_rd_f;
    logic [31:0]   r_rd_r;

    logic          w_we;
    logic [IW-1:0] w_wa;
    logic [31:0]   w_wd;

    logic          w_sch_start;
    logic          w_sch_done;
    logic [31:0]   w_sch_word;

    logic [31:0]   w_sum;
    logic [IW-1:0] w_front_inc;
    logic [IW-1:0] w_rear_inc;
    logic          w_out_free;

    alfr_schrage u_sch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sch_start),
        .i_word  (r_word),
        .o_done  (w_sch_done),
        .o_word  (w_sch_word)
    );

    // Ring write port and both read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_f <= r_mem[r_front];
        r_rd_r <= r_mem[r_rear];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alfr_pkg::S_SEED_FIRST;
            r_front     <= SEP;
            r_rear      <= '0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_word      <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_rear      <= n_rear;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_word      <= n_word;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign w_sum       = r_rd_f + r_rd_r;
    assign w_front_inc = (r_front == IDX_LAST) ? '0 : r_front + 1'b1;
    assign w_rear_inc  = (r_rear  == IDX_LAST) ? '0 : r_rear  + 1'b1;
    assign w_out_free  = !r_out_valid || o_out.ready;

    assign i_in.ready         = (r_state == alfr_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.random_value = r_out_data;

    // Sequencer: next state, ring writes and result register
    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_rear      = r_rear;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_word      = r_word;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_we        = 1'b0;
        w_wa        = r_front;
        w_wd        = w_sum;
        w_sch_start = 1'b0;

        // result taken by the sink
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            alfr_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.operation == alfr_pkg::OP_RESEED) begin
                        n_word  = (i_in.seed_value == '0) ? 32'd1 : i_in.seed_value;
                        n_state = alfr_pkg::S_SEED_FIRST;
                    end else begin
                        n_state = alfr_pkg::S_DRAW_RD;
                    end
                end
            end
            alfr_pkg::S_DRAW_RD: begin
                n_state = alfr_pkg::S_DRAW_WR;
            end
            alfr_pkg::S_DRAW_WR: begin
                // hold until the result register is free
                if (w_out_free) begin
                    w_we        = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_data  = w_sum[31:1];
                    n_front     = w_front_inc;
                    n_rear      = w_rear_inc;
                    n_state     = alfr_pkg::S_IDLE;
                end
            end
            alfr_pkg::S_SEED_FIRST: begin
                w_we    = 1'b1;
                w_wa    = '0;
                w_wd    = r_word;
                n_idx   = IW'(1);
                n_state = alfr_pkg::S_SEED_RUN;
            end
            alfr_pkg::S_SEED_RUN: begin
                w_sch_start = 1'b1;
                n_state     = alfr_pkg::S_SEED_WAIT;
            end
            alfr_pkg::S_SEED_WAIT: begin
                if (w_sch_done) begin
                    w_we   = 1'b1;
                    w_wa   = r_idx;
                    w_wd   = w_sch_word;
                    n_word = w_sch_word;
                    if (r_idx == IDX_LAST) begin
                        n_front = SEP;
                        n_rear  = '0;
                        n_cnt   = '0;
                        n_state = alfr_pkg::S_DISC_RD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = alfr_pkg::S_SEED_RUN;
                    end
                end
            end
            alfr_pkg::S_DISC_RD: begin
                n_state = alfr_pkg::S_DISC_WR;
            end
            alfr_pkg::S_DISC_WR: begin
                // discarded draw: update the ring, no result
                w_we    = 1'b1;
                n_front = w_front_inc;
                n_rear  = w_rear_inc;
                if (r_cnt == CNT_LAST) begin
                    n_state = alfr_pkg::S_IDLE;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = alfr_pkg::S_DISC_RD;
                end
            end
            default: begin
                n_state = alfr_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // Both ring pointers stay inside the ring
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_front <= IDX_LAST) && (r_rear <= IDX_LAST))
        else $error("ring pointer out of range");

    // When idle, front leads rear by the lag separation around the ring
    a_lag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alfr_pkg::S_IDLE) |->
        ((r_front >= r_rear) ? ((r_front - r_rear) == SEP)
                             : ((r_front + IW'(TABLE_DEGREE) - r_rear) == SEP)))
        else $error("front and rear pointers lost their separation");

    // The Schrage unit only reports while the sequencer waits for it
    a_sch_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sch_done |-> (r_state == alfr_pkg::S_SEED_WAIT))
        else $error("Schrage step finished outside a reseed");

    // A draw never overwrites a result that has not been transferred
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == alfr_pkg::S_DRAW_WR) && r_out_valid && !o_out.ready) |=>
        (r_state == alfr_pkg::S_DRAW_WR))
        else $error("draw result would overwrite a pending result");
`endif

endmodule

FILE: tb/alfr_checker.sv
// Checker for the lagged-Fibonacci generator: ring predictor and draw result comparison.
module alfr_checker #(
    parameter int TABLE_DEGREE   = 31,
    parameter int LAG_SEPARATION = 3
) (
    input  logic i_clk,
    input  logic i_rst_n,
    alfr_in_if   i_in,
    alfr_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted ring and indices
    logic [31:0] ring [TABLE_DEGREE];
    int          front_pos;
    int          rear_pos;

    // Draw values still owed by the block, oldest first
    logic [30:0] owed_draws [$];
    int          fail_total = 0;

    // One additive step: front += rear, both indices advance and wrap
    function automatic logic [30:0] ring_draw();
        logic [31:0] sum;
        sum             = ring[front_pos] + ring[rear_pos];
        ring[front_pos] = sum;
        front_pos       = (front_pos + 1 == TABLE_DEGREE) ? 0 : front_pos + 1;
        rear_pos        = (rear_pos + 1 == TABLE_DEGREE) ? 0 : rear_pos + 1;
        return sum[31:1];
    endfunction

    // Minimal-standard fill (Schrage, signed truncating division), then warm-up draws
    function automatic void ring_reseed(input logic [31:0] seed);
        logic [31:0] start;
        logic [30:0] dummy;
        longint      word;
        longint      quo;
        longint      rem;
        start   = (seed == 32'd0) ? 32'd1 : seed;
        ring[0] = start;
        word    = longint'($signed(start));
        for (int i = 1; i < TABLE_DEGREE; i++) begin
            quo  = word / longint'(alfr_pkg::PM_Q);
            rem  = word % longint'(alfr_pkg::PM_Q);
            word = longint'(alfr_pkg::PM_MULT) * rem - longint'(alfr_pkg::PM_R) * quo;
            if (word < 0) begin
                word += longint'(alfr_pkg::PM_MOD);
            end
            ring[i] = word[31:0];
        end
        front_pos = LAG_SEPARATION % TABLE_DEGREE;
        rear_pos  = 0;
        for (int n = 0; n < alfr_pkg::DISCARD_FACTOR * TABLE_DEGREE; n++) begin
            dummy = ring_draw();
        end
    endfunction

    // Watch both channels; requests first, then results
    always @(posedge i_clk) begin
        logic [30:0] want;
        if (!i_rst_n) begin
            // reset leaves the seed-one table
            ring_reseed(32'd1);
            owed_draws.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (i_in.operation == alfr_pkg::OP_RESEED) begin
                    ring_reseed(i_in.seed_value);
                end else begin
                    owed_draws.push_back(ring_draw());
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (owed_draws.size() == 0) begin
                    $error("random_value: expected none, actual %h", i_out.random_value);
                    fail_total++;
                end else begin
                    want = owed_draws.pop_front();
                    if (i_out.random_value !== want) begin
                        $error("random_value: expected %h, actual %h",
                               want, i_out.random_value);
                        fail_total++;
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= owed_draws.size();
    end

endmodule

FILE: tb/tb.sv
// Testbench top for the lagged-Fibonacci generator: clock, reset, stimulus and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEGREE       = 31;
    localparam int SEPARATION   = 3;
    localparam int RANDOM_ITEMS = 1330;
    localparam int RESEED_PCT   = 4;
    localparam int IDLE_PCT     = 27;
    // the tail leaves room for one more reseed after the owed draws
    localparam int TAIL_CYCLES  = 1300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 3000000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   pending_count;

    alfr_in_if  in_ch ();
    alfr_out_if out_ch ();

    always #5 i_clk = ~i_clk;

    additive_lagged_fibonacci_rng_core #(
        .TABLE_DEGREE   (DEGREE),
        .LAG_SEPARATION (SEPARATION)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    alfr_checker #(
        .TABLE_DEGREE   (DEGREE),
        .LAG_SEPARATION (SEPARATION)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Offer one request, with optional random gaps first, and wait for its transfer
    task automatic offer_request(input logic op, input logic [31:0] seed, input bit steady);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_ch.valid      <= 1'b1;
        in_ch.operation  <= op;
        in_ch.seed_value <= seed;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stop offering until every owed draw has come back
    task automatic drain_draws();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // Seeds weighted towards zero, small, negative and near-maximum values
    function automatic logic [31:0] pick_seed();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return $urandom_range(200, 1);
            2:       return 32'h8000_0000 | $urandom;
            3:       return 32'h7fff_ffff - $urandom_range(1000);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random back-pressure, a quiet stretch and two long hold-offs
    initial begin
        int hold_left;
        int results_seen;
        hold_left    = 0;
        results_seen = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (results_seen == 200 || results_seen == 800) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (results_seen >= 380 && results_seen < 650) begin
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog
    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Request side and verdict
    initial begin
        bit steady;
        in_ch.valid      = 1'b0;
        in_ch.operation  = alfr_pkg::OP_DRAW;
        in_ch.seed_value = 32'd0;
        i_rst_n          = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // draws straight from the reset table; the seed field is ignored here
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'hffff_ffff, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'hffff_ffff, 1'b0);
        // zero seed behaves as one
        offer_request(alfr_pkg::OP_RESEED, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_RESEED, 32'h0000_0001, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        // largest positive, most negative and minus one
        offer_request(alfr_pkg::OP_RESEED, 32'h7fff_ffff, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_RESEED, 32'h8000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_RESEED, 32'hffff_ffff, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        // seed equal to the Schrage divisor PM_Q: first difference goes negative
        offer_request(alfr_pkg::OP_RESEED, 32'd127773, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        // back-to-back reseeds, the second one wins
        offer_request(alfr_pkg::OP_RESEED, 32'haaaa_aaaa, 1'b0);
        offer_request(alfr_pkg::OP_RESEED, 32'h5555_5555, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'h0000_0000, 1'b0);
        offer_request(alfr_pkg::OP_DRAW, 32'hffff_ffff, 1'b0);
        drain_draws();

        // mostly draws, occasional reseeds
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 900) begin
                drain_draws();
            end
            steady = (n >= 400 && n < 650);
            if ($urandom_range(99) < RESEED_PCT) begin
                offer_request(alfr_pkg::OP_RESEED, pick_seed(), steady);
            end else begin
                offer_request(alfr_pkg::OP_DRAW, $urandom, steady);
            end
        end

        // wind down: owed draws, then room for a trailing reseed
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
